[design/lpq_pkg.sv]
// Shared types, constants and helpers for the linear priority queue.
// No dependencies; every other file imports this package.
package lpq_pkg;

    localparam int DEPTH    = 16;
    localparam int FIND_MAX = 8;

    localparam int DATA_W = 32;
    localparam int PRI_W  = 8;
    localparam int POS_W  = 4;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FCNT_W = $clog2(FIND_MAX + 2);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_FIND    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
        logic [PRI_W-1:0]  pri;
    } t_wr_req;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [DATA_W-1:0] data;
        logic [PRI_W-1:0]  pri;
        logic [POS_W-1:0]  pos;
        logic              trunc;
        logic              last;
    } t_result;

    function automatic t_result mk_res(t_status st, logic [DATA_W-1:0] d,
                                       logic [PRI_W-1:0] p, logic [IDX_W-1:0] idx,
                                       logic tr, logic lst);
        t_result r;
        r.valid  = 1'b1;
        r.status = st;
        r.data   = d;
        r.pri    = p;
        r.pos    = POS_W'(idx);
        r.trunc  = tr;
        r.last   = lst;
        return r;
    endfunction

endpackage

[design/linear_priority_queue.sv]
// Insert, clear and any request on an empty queue answer in the cycle after the request,
// and the block does not go busy for them. Extract scans up to count entries, one a cycle,
// registers its result as the scan ends, then compacts the entries behind it while busy.
// Find walks the store twice: first it counts the matches, then it reports them.
// The entry store takes one read and one write a cycle; results never stall.
// Reset is synchronous: the queue empties and the stop level returns to 255; no clearing pass.
module linear_priority_queue import lpq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_data_value,
    input  logic [PRI_W-1:0]  i_priority_value,
    input  logic              i_cfg_we,
    input  logic [PRI_W-1:0]  i_cfg_wdata,
    output logic              o_result_valid,
    output logic [ST_W-1:0]   o_status,
    output logic [DATA_W-1:0] o_out_data,
    output logic [PRI_W-1:0]  o_out_priority,
    output logic [POS_W-1:0]  o_position,
    output logic              o_truncated,
    output logic              o_last
);

    logic [PRI_W-1:0]  r_max_pri;
    t_wr_req           wr;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;
    logic [PRI_W-1:0]  rpri;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pri <= '1;
        end else if (i_cfg_we) begin
            r_max_pri <= i_cfg_wdata;
        end
    end

    lpq_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_opcode         (i_opcode),
        .i_data_value     (i_data_value),
        .i_priority_value (i_priority_value),
        .i_max_pri        (r_max_pri),
        .o_busy           (busy),
        .o_wr             (wr),
        .o_raddr          (raddr),
        .i_rdata          (rdata),
        .i_rpri           (rpri),
        .o_res            (res)
    );

    lpq_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata),
        .o_rpri  (rpri)
    );

    assign o_result_valid = res.valid;
    assign o_status       = res.status;
    assign o_out_data     = res.data;
    assign o_out_priority = res.pri;
    assign o_position     = res.pos;
    assign o_truncated    = res.trunc;
    assign o_last         = res.last;

endmodule

[design/lpq_store.sv]
// Entry storage: data and priority arrays, one write and one read port.
// Depends on lpq_pkg for widths and the write request struct.
module lpq_store import lpq_pkg::*; (
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [DATA_W-1:0] o_rdata,
    output logic [PRI_W-1:0]  o_rpri
);

    logic [DATA_W-1:0] r_data [DEPTH];
    logic [PRI_W-1:0]  r_pri  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_data[i_wr.addr] <= i_wr.data;
            r_pri[i_wr.addr]  <= i_wr.pri;
        end
    end

    assign o_rdata = r_data[i_raddr];
    assign o_rpri  = r_pri[i_raddr];

endmodule

[design/lpq_seq.sv]
// Sequencer for the queue: walks the store one entry a cycle, with a shared compare
// unit for extract scan and find; compaction needs no compare. Depends on lpq_pkg.
module lpq_seq import lpq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_data_value,
    input  logic [PRI_W-1:0]  i_priority_value,
    input  logic [PRI_W-1:0]  i_max_pri,
    output logic              o_busy,
    output t_wr_req           o_wr,
    output logic [IDX_W-1:0]  o_raddr,
    input  logic [DATA_W-1:0] i_rdata,
    input  logic [PRI_W-1:0]  i_rpri,
    output t_result           o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_COUNT,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_best, n_best;
    logic [PRI_W-1:0]   r_best_pri, n_best_pri;
    logic [DATA_W-1:0]  r_best_data, n_best_data;
    logic [DATA_W-1:0]  r_key, n_key;
    logic [FCNT_W-1:0]  r_matches, n_matches;
    logic [FCNT_W-1:0]  r_emitted, n_emitted;
    logic [FCNT_W-1:0]  r_total, n_total;
    logic               r_trunc, n_trunc;
    t_result            r_res, n_res;

    logic [CNT_W-1:0]   idx_inc;
    logic               is_empty;
    logic               key_hit;
    logic               pri_gt;
    logic               at_max;
    logic               take;
    logic               stop;
    logic               trunc_now;

    assign idx_inc  = r_idx + CNT_W'(1);
    assign is_empty = (r_count == '0);
    // shared compare unit
    assign key_hit  = (i_rdata == r_key);
    assign pri_gt   = (i_rpri > r_best_pri);
    assign at_max   = (r_best_pri == i_max_pri);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_pri  = r_best_pri;
        n_best_data = r_best_data;
        n_key       = r_key;
        n_matches   = r_matches;
        n_emitted   = r_emitted;
        n_total     = r_total;
        n_trunc     = r_trunc;
        n_res       = r_res;
        n_res.valid = 1'b0;
        o_wr        = '0;
        o_raddr     = r_idx[IDX_W-1:0];
        take        = 1'b0;
        stop        = 1'b0;
        trunc_now   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (t_op'(i_opcode))
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_res = mk_res(ST_FULL, '0, '0, '0, 1'b0, 1'b1);
                            end else begin
                                o_wr.we   = 1'b1;
                                o_wr.addr = r_count[IDX_W-1:0];
                                o_wr.data = i_data_value;
                                o_wr.pri  = i_priority_value;
                                n_count   = r_count + CNT_W'(1);
                                n_res     = mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                            end
                        end
                        OP_EXTRACT: begin
                            if (is_empty) begin
                                n_res = mk_res(ST_EMPTY, '0, '0, '0, 1'b0, 1'b1);
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            if (is_empty) begin
                                n_res = mk_res(ST_EMPTY, '0, '0, '0, 1'b0, 1'b1);
                            end else begin
                                n_count = '0;
                                n_res   = mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                            end
                        end
                        OP_FIND: begin
                            if (is_empty) begin
                                n_res = mk_res(ST_EMPTY, '0, '0, '0, 1'b0, 1'b1);
                            end else begin
                                n_key     = i_data_value;
                                n_idx     = '0;
                                n_matches = '0;
                                n_state   = S_COUNT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // front entry seeds the best; later ones replace it only if strictly greater
                stop = (r_idx != '0) && at_max;
                take = (r_idx == '0) || (!at_max && pri_gt);
                if (take) begin
                    n_best      = r_idx[IDX_W-1:0];
                    n_best_pri  = i_rpri;
                    n_best_data = i_rdata;
                end
                if (stop || (idx_inc == r_count)) begin
                    n_res   = mk_res(ST_OK, n_best_data, n_best_pri, n_best, 1'b0, 1'b1);
                    n_idx   = CNT_W'(n_best);
                    n_state = S_SHIFT;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_SHIFT: begin
                // move later entries up one place to close the gap
                o_raddr = idx_inc[IDX_W-1:0];
                if (idx_inc < r_count) begin
                    o_wr.we   = 1'b1;
                    o_wr.addr = r_idx[IDX_W-1:0];
                    o_wr.data = i_rdata;
                    o_wr.pri  = i_rpri;
                    n_idx     = idx_inc;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_COUNT: begin
                // saturate one above the cap so truncation is still visible
                if (key_hit && (r_matches <= FCNT_W'(FIND_MAX))) begin
                    n_matches = r_matches + FCNT_W'(1);
                end
                if (idx_inc == r_count) begin
                    if (n_matches == '0) begin
                        n_res   = mk_res(ST_NOTFOUND, '0, '0, '0, 1'b0, 1'b1);
                        n_state = S_IDLE;
                    end else begin
                        trunc_now = (n_matches > FCNT_W'(FIND_MAX));
                        n_trunc   = trunc_now;
                        n_total   = trunc_now ? FCNT_W'(FIND_MAX) : n_matches;
                        n_idx     = '0;
                        n_emitted = '0;
                        n_state   = S_EMIT;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_EMIT: begin
                if (key_hit) begin
                    n_emitted = r_emitted + FCNT_W'(1);
                    n_res     = mk_res(ST_OK, i_rdata, i_rpri, r_idx[IDX_W-1:0], r_trunc,
                                       n_emitted == r_total);
                    if (n_emitted == r_total) begin
                        n_state = S_IDLE;
                    end
                end
                n_idx = idx_inc;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_res   <= n_res;
        end
        r_idx       <= n_idx;
        r_best      <= n_best;
        r_best_pri  <= n_best_pri;
        r_best_data <= n_best_data;
        r_key       <= n_key;
        r_matches   <= n_matches;
        r_emitted   <= n_emitted;
        r_total     <= n_total;
        r_trunc     <= n_trunc;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

[design/lpq_checker.sv]
// Port-level checks for the linear priority queue, bound to the top level.
// Depends on lpq_pkg for widths and status codes.
module lpq_props import lpq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input logic [ST_W-1:0]   o_status,
    input logic [DATA_W-1:0] o_out_data,
    input logic [PRI_W-1:0]  o_out_priority,
    input logic              o_truncated,
    input logic              o_last
);

    // every request taken while idle either answers at once or keeps the block busy
    a_req_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("request neither answered nor in progress");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !busy) |-> o_last)
        else $error("result shown while idle is not marked last");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != ST_OK)) |->
            (o_last && (o_out_data == '0) && (o_out_priority == '0)))
        else $error("failed request carries payload or is not last");

    a_trunc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_truncated) |-> (o_status == ST_OK))
        else $error("truncation flag on a failed result");

endmodule

bind linear_priority_queue lpq_props u_lpq_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_out_data     (o_out_data),
    .o_out_priority (o_out_priority),
    .o_truncated    (o_truncated),
    .o_last         (o_last)
);

[verif/lpq_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the linear priority queue: mirrors the stored entries and the stop level,
// predicts the replies of every accepted request and checks each result strobe in order.
// Depends on lpq_pkg for widths, opcodes and status codes.
module lpq_checker import lpq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_data_value,
    input  logic [PRI_W-1:0]  i_priority_value,
    input  logic              i_cfg_we,
    input  logic [PRI_W-1:0]  i_cfg_wdata,
    input  logic              i_result_valid,
    input  logic [ST_W-1:0]   i_status,
    input  logic [DATA_W-1:0] i_out_data,
    input  logic [PRI_W-1:0]  i_out_priority,
    input  logic [POS_W-1:0]  i_position,
    input  logic              i_truncated,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] data;
        logic [PRI_W-1:0]  pri;
        logic [POS_W-1:0]  pos;
        logic              trunc;
        logic              last;
    } t_queue_reply;

    t_queue_reply      awaited_replies[$];
    logic [DATA_W-1:0] slot_data [DEPTH];
    logic [PRI_W-1:0]  slot_pri [DEPTH];
    int                slot_count = 0;
    logic [PRI_W-1:0]  stop_pri = 8'hFF;
    int                mismatch_count = 0;
    int                awaited_level = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = awaited_level;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic push_reply(t_status st, logic [DATA_W-1:0] d, logic [PRI_W-1:0] p,
                              int pos, logic tr, logic lst);
        t_queue_reply r;
        r.status = st;
        r.data   = d;
        r.pri    = p;
        r.pos    = POS_W'(pos);
        r.trunc  = tr;
        r.last   = lst;
        awaited_replies.push_back(r);
    endtask

    task automatic predict_request(t_op op, logic [DATA_W-1:0] key, logic [PRI_W-1:0] pri);
        int  best;
        int  hits;
        int  total;
        int  n;
        int  i;
        logic tr;
        if (op == OP_INSERT) begin
            if (slot_count >= DEPTH) begin
                push_reply(ST_FULL, '0, '0, 0, 1'b0, 1'b1);
            end else begin
                slot_data[slot_count] = key;
                slot_pri[slot_count]  = pri;
                slot_count++;
                push_reply(ST_OK, '0, '0, 0, 1'b0, 1'b1);
            end
        end else if (slot_count == 0) begin
            push_reply(ST_EMPTY, '0, '0, 0, 1'b0, 1'b1);
        end else if (op == OP_EXTRACT) begin
            // first strictly greater wins; stop once the best hits the stop level
            best = 0;
            for (i = 1; i < slot_count; i++) begin
                if (slot_pri[best] == stop_pri) break;
                if (slot_pri[i] > slot_pri[best]) best = i;
            end
            push_reply(ST_OK, slot_data[best], slot_pri[best], best, 1'b0, 1'b1);
            for (i = best; i + 1 < slot_count; i++) begin
                slot_data[i] = slot_data[i + 1];
                slot_pri[i]  = slot_pri[i + 1];
            end
            slot_count--;
        end else if (op == OP_CLEAR) begin
            slot_count = 0;
            push_reply(ST_OK, '0, '0, 0, 1'b0, 1'b1);
        end else begin
            hits = 0;
            for (i = 0; i < slot_count; i++) begin
                if (slot_data[i] == key) hits++;
            end
            if (hits == 0) begin
                push_reply(ST_NOTFOUND, '0, '0, 0, 1'b0, 1'b1);
            end else begin
                tr    = (hits > FIND_MAX);
                total = tr ? FIND_MAX : hits;
                n     = 0;
                for (i = 0; i < slot_count && n < total; i++) begin
                    if (slot_data[i] == key) begin
                        push_reply(ST_OK, slot_data[i], slot_pri[i], i, tr, (n + 1 == total));
                        n++;
                    end
                end
            end
        end
    endtask

    task automatic check_result();
        t_queue_reply r;
        if (awaited_replies.size() == 0) begin
            report_mismatch("result with no request awaiting it, status", 32'(i_status), 0);
        end else begin
            r = awaited_replies.pop_front();
            if (i_status !== r.status) report_mismatch("status", 32'(i_status), 32'(r.status));
            if (i_out_data !== r.data) report_mismatch("out_data", i_out_data, r.data);
            if (i_out_priority !== r.pri)
                report_mismatch("out_priority", 32'(i_out_priority), 32'(r.pri));
            if (i_position !== r.pos) report_mismatch("position", 32'(i_position), 32'(r.pos));
            if (i_truncated !== r.trunc)
                report_mismatch("truncated", 32'(i_truncated), 32'(r.trunc));
            if (i_last !== r.last) report_mismatch("last", 32'(i_last), 32'(r.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_count = 0;
            stop_pri   = 8'hFF;
            awaited_replies.delete();
        end else begin
            // results belong to earlier requests, so check them before predicting
            if (i_result_valid === 1'b1) check_result();
            if (i_cfg_we) stop_pri = i_cfg_wdata;
            if (i_start && !i_busy) predict_request(t_op'(i_opcode), i_data_value, i_priority_value);
        end
        awaited_level <= awaited_replies.size();
    end

endmodule

[verif/linear_priority_queue_tb.sv]
`timescale 1ns / 100ps
// Top of the linear priority queue testbench: clock, reset, requests and the verdict.
// Depends on lpq_pkg, linear_priority_queue and lpq_checker.
module linear_priority_queue_tb;
    import lpq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          ITEMS_PER_PHASE = 30;
    localparam logic [DATA_W-1:0] DUP_KEY = 32'hA5A5_A5A5;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_opcode = OP_INSERT;
    logic [DATA_W-1:0] i_data_value = '0;
    logic [PRI_W-1:0]  i_priority_value = '0;
    logic              i_cfg_we = 1'b0;
    logic [PRI_W-1:0]  i_cfg_wdata = '0;
    logic              o_result_valid;
    logic [ST_W-1:0]   o_status;
    logic [DATA_W-1:0] o_out_data;
    logic [PRI_W-1:0]  o_out_priority;
    logic [POS_W-1:0]  o_position;
    logic              o_truncated;
    logic              o_last;

    int                fail_count;
    int                pending_replies;
    int unsigned       cycle_count = 0;
    bit                gaps_on = 1'b1;
    logic [DATA_W-1:0] key_pool [4];

    linear_priority_queue u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_data_value     (i_data_value),
        .i_priority_value (i_priority_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_out_data       (o_out_data),
        .o_out_priority   (o_out_priority),
        .o_position       (o_position),
        .o_truncated      (o_truncated),
        .o_last           (o_last)
    );

    lpq_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (i_opcode),
        .i_data_value     (i_data_value),
        .i_priority_value (i_priority_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_result_valid   (o_result_valid),
        .i_status         (o_status),
        .i_out_data       (o_out_data),
        .i_out_priority   (o_out_priority),
        .i_position       (o_position),
        .i_truncated      (o_truncated),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending_replies)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(t_op op, logic [DATA_W-1:0] d, logic [PRI_W-1:0] p);
        if (gaps_on) begin
            while ($urandom_range(99) < 13) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start            <= 1'b1;
        i_opcode         <= op;
        i_data_value     <= d;
        i_priority_value <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start and wait until every reply is in and the block is quiet.
    task automatic drain_queue_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_replies != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_stop_level(logic [PRI_W-1:0] level);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= level;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_random_request(logic [PRI_W-1:0] stop_level);
        int                sel;
        t_op               op;
        logic [DATA_W-1:0] d;
        logic [PRI_W-1:0]  p;
        sel = $urandom_range(99);
        if (sel < 45) op = OP_INSERT;
        else if (sel < 70) op = OP_EXTRACT;
        else if (sel < 93) op = OP_FIND;
        else op = OP_CLEAR;
        // reuse a few keys so that finds hit, often more than once
        d = ($urandom_range(9) < 7) ? key_pool[$urandom_range(3)] : DATA_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 25) p = stop_level;
        else if (sel < 40) p = '0;
        else if (sel < 55) p = '1;
        else p = PRI_W'($urandom_range(255));
        send_request(op, d, p);
    endtask

    initial begin
        logic [PRI_W-1:0] levels [5];
        logic [DATA_W-1:0] d;
        logic [PRI_W-1:0]  p;
        int i;
        int ph;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_stop_level(8'hFF);

        // empty queue on every non-insert opcode
        send_request(OP_EXTRACT, '1, '1);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_FIND, DUP_KEY, '0);

        // fill to capacity: ten copies of one key, extremes of data and priority
        for (i = 0; i < DEPTH; i++) begin
            if (i < 10) d = DUP_KEY;
            else if (i == 10) d = '0;
            else if (i == 11) d = '1;
            else d = DATA_W'($urandom);
            if (i == 0) p = '0;
            else if (i == 5 || i == 11) p = '1;
            else p = PRI_W'((i * 23) & 8'hFF);
            send_request(OP_INSERT, d, p);
        end
        send_request(OP_INSERT, 32'hDEAD_BEEF, 8'h80);
        send_request(OP_FIND, DUP_KEY, '0);
        send_request(OP_FIND, 32'h1234_5678, '0);
        send_request(OP_FIND, '0, '1);
        send_request(OP_EXTRACT, '0, '0);
        send_request(OP_CLEAR, '1, '1);
        drain_queue_replies();

        levels[0] = 8'd0;
        levels[1] = PRI_W'($urandom_range(2, 254));
        levels[2] = 8'd1;
        levels[3] = 8'd128;
        levels[4] = 8'd255;
        for (ph = 0; ph < 5; ph++) begin
            write_stop_level(levels[ph]);
            key_pool[0] = DATA_W'($urandom);
            key_pool[1] = DATA_W'($urandom);
            key_pool[2] = '0;
            key_pool[3] = '1;
            gaps_on = (ph != 2);
            for (i = 0; i < ITEMS_PER_PHASE; i++) send_random_request(levels[ph]);
            drain_queue_replies();
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_replies == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/lpq_pkg.sv
design/lpq_store.sv
design/lpq_seq.sv
design/linear_priority_queue.sv
design/lpq_checker.sv
verif/lpq_checker.sv
verif/linear_priority_queue_tb.sv
